// File: rtl/core/htc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htc_pkg
// Shared types, character codes and the entity table of the text collapser.
// ----------------------------------------------------------------------------
package htc_pkg;

  localparam int BUF_BYTES = 6;
  localparam int BUF_W     = BUF_BYTES * 8;
  localparam int ENT_NUM   = 5;
  localparam int ENT_PRE   = 5;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;
  localparam logic [7:0] CH_DQ  = 8'h22;

  localparam logic [11:0] MAX_CHARS_RST = 12'd511;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } htc_cmd_t;

  typedef struct packed {
    logic work;
    logic out_free;
  } htc_stat_t;

  // entity text, first character in the top byte, padded with zero
  function automatic logic [7:0] ent_byte_of(input logic [2:0] k, input logic [2:0] i);
    logic [47:0] s;
    logic [47:0] t;
    unique case (k)
      3'd0:    s = {"&amp;", 8'h00};
      3'd1:    s = {"&lt;", 16'h0000};
      3'd2:    s = {"&gt;", 16'h0000};
      3'd3:    s = "&quot;";
      3'd4:    s = "&nbsp;";
      default: s = '0;
    endcase
    t = s << {i, 3'b000};
    return t[47:40];
  endfunction

  function automatic logic [2:0] ent_len_of(input logic [2:0] k);
    unique case (k)
      3'd0:    return 3'd5;
      3'd1:    return 3'd4;
      3'd2:    return 3'd4;
      3'd3:    return 3'd6;
      3'd4:    return 3'd6;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] ent_val_of(input logic [2:0] k);
    unique case (k)
      3'd0:    return CH_AMP;
      3'd1:    return CH_LT;
      3'd2:    return CH_GT;
      3'd3:    return CH_DQ;
      3'd4:    return CH_SP;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) || (c == CH_SP);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/htc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htc_ctrl
// Sequencer: takes a byte, runs datapath steps until the byte is done, then
// closes the byte with a finish step.
// ----------------------------------------------------------------------------
module htc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire htc_pkg::htc_stat_t stat,
  output htc_pkg::htc_cmd_t      cmd
);
  import htc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.out_free) begin
          if (stat.work) begin
            cmd.step = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/htc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htc_datapath
// Byte queue with entity prefix, tag and whitespace state, character
// counter, one-character hold stage and output register.
// ----------------------------------------------------------------------------
module htc_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [11:0]       cfg_wdata,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  input  wire htc_pkg::htc_cmd_t cmd,
  output htc_pkg::htc_stat_t     stat,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);
  import htc_pkg::*;

  localparam logic [1:0] EXT_NONE   = 2'd0;
  localparam logic [1:0] EXT_PREFIX = 2'd1;
  localparam logic [1:0] EXT_DONE   = 2'd2;

  logic [11:0]      max_chars;
  logic [11:0]      count;
  logic             inside_tag;
  logic             space_pending;
  logic             full;
  logic             last_q;
  logic [BUF_W-1:0] qbuf;
  logic [2:0]       cnt;
  logic [2:0]       ent_len;
  logic             pend_v;
  logic [7:0]       pend_char;

  logic [BUF_W-1:0] qbuf_sh;
  logic [BUF_W-1:0] qbuf_ld;
  logic [7:0]       head;
  logic             have_q;
  logic             flush_case;
  logic [1:0]       ext_r;
  logic [7:0]       ext_val;

  logic             inside_next;
  logic             space_next;
  logic [2:0]       ent_len_next;
  logic [2:0]       shift_k;
  logic             emit;
  logic [7:0]       emit_char;
  logic             tc_en;
  logic [7:0]       tc_c;
  logic [2:0]       tc_k;

  assign qbuf_sh    = qbuf >> {ent_len, 3'b000};
  assign head       = qbuf_sh[7:0];
  assign have_q     = (cnt > ent_len);
  assign flush_case = !have_q && last_q && (ent_len != 3'd0);
  assign qbuf_ld    = (qbuf & ~({{(BUF_W-8){1'b0}}, 8'hFF} << {cnt, 3'b000}))
                    | ({{(BUF_W-8){1'b0}}, in_byte} << {cnt, 3'b000});

  assign stat.work     = !full && (have_q || flush_case);
  assign stat.out_free = !m_axis_tvalid || m_axis_tready;

  // entity prefix extension
  always_comb begin
    logic ok;
    ext_r   = EXT_NONE;
    ext_val = 8'h00;
    for (int k = ENT_NUM - 1; k >= 0; k--) begin
      ok = (ent_len < ent_len_of(3'(k)));
      for (int i = 0; i < ENT_PRE; i++) begin
        if ((3'(i) < ent_len) && (ent_byte_of(3'(k), 3'(i)) != qbuf[8*i +: 8])) begin
          ok = 1'b0;
        end
      end
      if (ent_byte_of(3'(k), ent_len) != head) begin
        ok = 1'b0;
      end
      if (ok) begin
        ext_r   = ((ent_len + 3'd1) == ent_len_of(3'(k))) ? EXT_DONE : EXT_PREFIX;
        ext_val = ent_val_of(3'(k));
      end
    end
  end

  // one processing step
  always_comb begin
    inside_next  = inside_tag;
    space_next   = space_pending;
    ent_len_next = ent_len;
    shift_k      = 3'd0;
    emit         = 1'b0;
    emit_char    = head;
    tc_en        = 1'b0;
    tc_c         = head;
    tc_k         = 3'd0;
    if (ent_len == 3'd0) begin
      if (head == CH_LT) begin
        inside_next = 1'b1;
        space_next  = 1'b1;
        shift_k     = 3'd1;
      end else if (inside_tag) begin
        if (head == CH_GT) inside_next = 1'b0;
        shift_k = 3'd1;
      end else if (head == CH_AMP) begin
        ent_len_next = 3'd1;
      end else begin
        tc_en = 1'b1;
        tc_c  = head;
        tc_k  = 3'd1;
      end
    end else if (flush_case || (ext_r == EXT_NONE)) begin
      tc_en = 1'b1;
      tc_c  = CH_AMP;
      tc_k  = 3'd1;
    end else if (ext_r == EXT_PREFIX) begin
      ent_len_next = ent_len + 3'd1;
    end else begin
      tc_en = 1'b1;
      tc_c  = ext_val;
      tc_k  = ent_len + 3'd1;
    end
    if (tc_en) begin
      if (is_ws(tc_c)) begin
        space_next   = 1'b1;
        shift_k      = tc_k;
        ent_len_next = 3'd0;
      end else if (space_pending && (count != 12'd0)) begin
        // pending space goes first, same byte is looked at again
        emit       = 1'b1;
        emit_char  = CH_SP;
        space_next = 1'b0;
      end else begin
        space_next   = 1'b0;
        emit         = 1'b1;
        emit_char    = tc_c;
        shift_k      = tc_k;
        ent_len_next = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars     <= MAX_CHARS_RST;
      count         <= '0;
      inside_tag    <= 1'b0;
      space_pending <= 1'b0;
      full          <= 1'b0;
      last_q        <= 1'b0;
      cnt           <= '0;
      ent_len       <= '0;
      pend_v        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) max_chars <= cfg_wdata;
      if ((cmd.step && emit && pend_v) || (cmd.finish && (pend_v || last_q))) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cmd.load) begin
        cnt    <= cnt + 3'd1;
        last_q <= in_last;
        if (count >= max_chars) full <= 1'b1;
      end
      if (cmd.step) begin
        inside_tag    <= inside_next;
        space_pending <= space_next;
        ent_len       <= ent_len_next;
        cnt           <= cnt - shift_k;
        if (emit) begin
          count  <= count + 12'd1;
          pend_v <= 1'b1;
          if ((count + 12'd1) == max_chars) full <= 1'b1;
        end
      end
      if (cmd.finish) begin
        pend_v <= 1'b0;
        if (last_q) begin
          count         <= '0;
          inside_tag    <= 1'b0;
          space_pending <= 1'b0;
          full          <= 1'b0;
          last_q        <= 1'b0;
          cnt           <= '0;
          ent_len       <= '0;
        end else if (full) begin
          cnt     <= '0;
          ent_len <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qbuf <= qbuf_ld;
    end else if (cmd.step) begin
      qbuf <= qbuf >> {shift_k, 3'b000};
    end
    if (cmd.step && emit) begin
      pend_char <= emit_char;
      if (pend_v) begin
        m_axis_tdata <= pend_char;
        m_axis_tuser <= 1'b1;
        m_axis_tlast <= 1'b0;
      end
    end
    if (cmd.finish) begin
      if (pend_v) begin
        m_axis_tdata <= pend_char;
        m_axis_tuser <= 1'b1;
        m_axis_tlast <= last_q;
      end else if (last_q) begin
        m_axis_tdata <= 8'h00;
        m_axis_tuser <= 1'b0;
        m_axis_tlast <= 1'b1;
      end
    end
  end

  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    (ent_len <= cnt) && (cnt <= 3'(BUF_BYTES)))
    else $error("byte queue out of bounds");

  a_run_cleared: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && last_q) |=> (count == 12'd0) && !full && !inside_tag && (cnt == 3'd0))
    else $error("run state not cleared after final byte");

  a_no_emit_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && emit) |-> !full)
    else $error("character emitted past the limit");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.finish) |-> stat.out_free)
    else $error("output register overwritten while held");

endmodule
`default_nettype wire

// File: rtl/core/html_text_collapser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// html_text_collapser
// Streaming HTML body to plain text reducer, one input byte per transfer.
// ----------------------------------------------------------------------------
// Each accepted byte is loaded into the byte queue, then the step unit handles
// every byte in turn (the new byte and any bytes of a failed entity prefix
// that are replayed, up to six), every extra space emitted before a character
// and the flush of a partial entity at the end of a run; a finish step then
// closes the byte. Characters pass through a one-character hold stage so the
// final one can carry tlast; a byte's last character leaves when that byte
// is closed. The single step unit handles one byte or one character per
// cycle while the output register is free; steps wait while the output
// register holds an untaken transfer. A final byte that produces no
// character yields one transfer with tuser low and tlast high, after which
// a new run starts. max_chars may only be written while the block is idle.
// ----------------------------------------------------------------------------
module html_text_collapser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,      // max_chars
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  input  wire logic        s_axis_tlast,   // in_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_char
  output logic             m_axis_tuser,   // char_valid
  output logic             m_axis_tlast    // end_of_text
);
  import htc_pkg::*;

  htc_cmd_t  cmd;
  htc_stat_t stat;

  htc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  htc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_byte       (s_axis_tdata),
    .in_last       (s_axis_tlast),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// File: tb/sv/html_text_collapser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_text_collapser_tb
// Drives HTML body bytes into the text collapser and checks every emitted
// character transfer against a cycle-free predictor of the collapsing rules:
// tag removal, entity decoding with replay of broken entities, whitespace
// folding, the character limit and end-of-run marking. Covers directed
// cases, output back-pressure and random tag/entity/text runs under random
// source gaps and sink stalls.
// ----------------------------------------------------------------------------
module html_text_collapser_tb;
  import htc_pkg::*;

  localparam int MAX_PER_BYTE = 9;
  localparam int QUIET_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 56;
  localparam int DRAIN_LIMIT  = 20000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       eot;
  } char_xfer_t;

  typedef enum int {ENT_FAIL, ENT_PREFIX, ENT_DONE} ent_match_e;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [11:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // in_byte
  logic        s_axis_tlast;   // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // out_char
  logic        m_axis_tuser;   // char_valid
  logic        m_axis_tlast;   // end_of_text

  html_text_collapser dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  char_xfer_t  pending_chars[$];
  char_xfer_t  step_chars[$];
  int          mismatches   = 0;
  int          random_items = 0;
  bit          idle_on      = 1'b1;
  bit          hold_req     = 1'b0;

  logic [11:0] max_chars_m;
  logic        in_tag_m;
  logic        space_m;
  logic        full_m;
  logic [11:0] count_m;
  logic [7:0]  ent_m[5];
  int          ent_len_m;

  string       ent_txt[5]  = '{"&amp;", "&lt;", "&gt;", "&quot;", "&nbsp;"};
  logic [7:0]  ent_char[5] = '{CH_AMP, CH_LT, CH_GT, CH_DQ, CH_SP};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("html_text_collapser_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_run_model();
    in_tag_m  = 1'b0;
    space_m   = 1'b0;
    count_m   = 12'd0;
    full_m    = 1'b0;
    ent_len_m = 0;
    for (int i = 0; i < 5; i++) ent_m[i] = 8'h00;
  endfunction

  function automatic void put_out(input logic [7:0] c);
    if (full_m) return;
    if (count_m >= max_chars_m) begin
      full_m = 1'b1;
      return;
    end
    if (step_chars.size() < MAX_PER_BYTE) step_chars.push_back('{c, 1'b1, 1'b0});
    count_m = count_m + 12'd1;
    if (count_m >= max_chars_m) full_m = 1'b1;
  endfunction

  function automatic void put_text(input logic [7:0] c);
    if (full_m) return;
    if (c == CH_CR || c == CH_LF || c == CH_TAB || c == CH_SP) begin
      space_m = 1'b1;
      return;
    end
    if (space_m && count_m > 12'd0) begin
      put_out(CH_SP);
      if (full_m) return;
    end
    space_m = 1'b0;
    put_out(c);
  endfunction

  function automatic void put_raw(input logic [7:0] c);
    if (full_m) return;
    if (c == CH_LT) begin
      in_tag_m = 1'b1;
      space_m  = 1'b1;
      return;
    end
    if (in_tag_m) begin
      if (c == CH_GT) in_tag_m = 1'b0;
      return;
    end
    if (c == CH_AMP) begin
      ent_m[0]  = c;
      ent_len_m = 1;
      return;
    end
    put_text(c);
  endfunction

  function automatic ent_match_e extend_entity(input logic [7:0] c, output logic [7:0] val);
    int n;
    bit ok;
    val = 8'h00;
    n = ent_len_m;
    for (int k = 0; k < 5; k++) begin
      if (n + 1 > ent_txt[k].len() || n > 5) continue;
      ok = 1'b1;
      for (int i = 0; i < n; i++) if (8'(ent_txt[k][i]) != ent_m[i]) ok = 1'b0;
      if (!ok || 8'(ent_txt[k][n]) != c) continue;
      if (n + 1 == ent_txt[k].len()) begin
        val = ent_char[k];
        return ENT_DONE;
      end
      return ENT_PREFIX;
    end
    return ENT_FAIL;
  endfunction

  function automatic void feed_bytes(input byte_q_t src);
    byte_q_t    work;
    logic [7:0] b;
    logic [7:0] val;
    ent_match_e r;
    work = src;
    while (work.size() > 0 && !full_m) begin
      b = work.pop_front();
      if (ent_len_m == 0) begin
        put_raw(b);
        continue;
      end
      r = extend_entity(b, val);
      if (r == ENT_PREFIX) begin
        if (ent_len_m < 5) ent_m[ent_len_m] = b;
        ent_len_m++;
        continue;
      end
      if (r == ENT_DONE) begin
        ent_len_m = 0;
        put_text(val);
        continue;
      end
      // broken entity: emit the ampersand, replay what followed it
      work.push_front(b);
      for (int i = ent_len_m - 1; i >= 1; i--) work.push_front(ent_m[i]);
      ent_len_m = 0;
      put_text(CH_AMP);
    end
  endfunction

  function automatic void flush_entity_model();
    byte_q_t rest;
    for (int g = 0; g < 6 && ent_len_m > 0; g++) begin
      rest.delete();
      for (int i = 1; i < ent_len_m && i < 5; i++) rest.push_back(ent_m[i]);
      ent_len_m = 0;
      put_text(CH_AMP);
      feed_bytes(rest);
    end
    ent_len_m = 0;
  endfunction

  function automatic void collapse_byte(input logic [7:0] b, input logic last);
    byte_q_t    one;
    char_xfer_t x;
    step_chars.delete();
    if (count_m >= max_chars_m) full_m = 1'b1;
    one.push_back(b);
    feed_bytes(one);
    if (last) begin
      flush_entity_model();
      if (step_chars.size() > 0) begin
        x = step_chars.pop_back();
        x.eot = 1'b1;
        step_chars.push_back(x);
      end else begin
        step_chars.push_back('{8'h00, 1'b0, 1'b1});
      end
      clear_run_model();
    end
    foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  initial begin
    char_xfer_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer char %02h valid %0b end %0b",
                                    m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = pending_chars.pop_front();
          if (m_axis_tdata !== want.ch)
            report_mismatch($sformatf("out_char %02h, want %02h", m_axis_tdata, want.ch));
          if (m_axis_tuser !== want.valid)
            report_mismatch($sformatf("char_valid %0b, want %0b", m_axis_tuser, want.valid));
          if (m_axis_tlast !== want.eot)
            report_mismatch($sformatf("end_of_text %0b, want %0b", m_axis_tlast, want.eot));
        end
      end
    end
  end

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready <= !(idle_on && ($urandom_range(99) < 29));
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_on && ($urandom_range(99) < 29)) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    collapse_byte(b, last);
  endtask

  task automatic send_text(input string s, input bit end_run);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]), end_run && (i == s.len() - 1));
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_chars(input logic [11:0] v);
    wait_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    max_chars_m = v;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_whitespace_and_tags();
    send_text(" \n\tA<p>\r", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_entities();
    send_text("&lt;&gt;&amp;&quot;&nbsp;", 1'b1);
  endtask

  task automatic test_broken_entities();
    send_text("&amx<a&b>&nbs", 1'b1);
  endtask

  task automatic test_char_limit();
    set_max_chars(12'd0);
    send_text("ab", 1'b1);
    set_max_chars(12'd2);
    send_text("a bc", 1'b1);
    // raising the limit mid-run must not resume output
    set_max_chars(12'd1);
    send_text("xy", 1'b0);
    set_max_chars(12'hFFF);
    send_text("z", 1'b1);
  endtask

  task automatic test_output_backpressure();
    set_max_chars(MAX_CHARS_RST);
    hold_req = 1'b1;
    for (int i = 0; i < 48; i++) send_byte(8'h61 + 8'(i % 26), i == 47);
  endtask

  task automatic random_run();
    byte_q_t run_bytes;
    int      target;
    int      pick;
    int      k;
    int      n;
    target = $urandom_range(1, 14);
    while (run_bytes.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        n = $urandom_range(1, 5);
        repeat (n) run_bytes.push_back(8'h61 + 8'($urandom_range(25)));
      end else if (pick < 45) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          case ($urandom_range(3))
            0:       run_bytes.push_back(CH_SP);
            1:       run_bytes.push_back(CH_TAB);
            2:       run_bytes.push_back(CH_LF);
            default: run_bytes.push_back(CH_CR);
          endcase
        end
      end else if (pick < 60) begin
        run_bytes.push_back(CH_LT);
        n = $urandom_range(0, 3);
        repeat (n) begin
          if ($urandom_range(3) == 0) run_bytes.push_back(CH_AMP);
          else run_bytes.push_back(8'h61 + 8'($urandom_range(25)));
        end
        if ($urandom_range(4) != 0) run_bytes.push_back(CH_GT);
      end else if (pick < 80) begin
        k = $urandom_range(4);
        for (int i = 0; i < ent_txt[k].len(); i++) run_bytes.push_back(8'(ent_txt[k][i]));
      end else if (pick < 90) begin
        k = $urandom_range(4);
        n = $urandom_range(1, ent_txt[k].len() - 1);
        for (int i = 0; i < n; i++) run_bytes.push_back(8'(ent_txt[k][i]));
        if ($urandom_range(1) == 1) run_bytes.push_back(8'($urandom_range(255)));
      end else begin
        run_bytes.push_back(8'($urandom_range(255)));
      end
    end
    foreach (run_bytes[i]) begin
      send_byte(run_bytes[i], i == run_bytes.size() - 1);
      random_items++;
    end
  endtask

  task automatic test_random_runs();
    logic [11:0] lim;
    set_max_chars(MAX_CHARS_RST);
    idle_on = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= 40) idle_on = 1'b1;
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(5))
          0:       lim = 12'd0;
          1:       lim = 12'($urandom_range(1, 6));
          2:       lim = MAX_CHARS_RST;
          3:       lim = 12'hFFF;
          default: lim = 12'($urandom_range(4095));
        endcase
        set_max_chars(lim);
      end
      random_run();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int waited;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = 12'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    max_chars_m   = MAX_CHARS_RST;
    clear_run_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_whitespace_and_tags();
    test_entities();
    test_broken_entities();
    test_char_limit();
    test_output_backpressure();
    test_random_runs();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_chars.size() != 0)
      report_mismatch($sformatf("%0d expected transfers never arrived", pending_chars.size()));
    repeat (QUIET_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("html_text_collapser_tb passed");
    end else begin
      $display("html_text_collapser_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/htc_pkg.sv
rtl/core/htc_ctrl.sv
rtl/core/htc_datapath.sv
rtl/core/html_text_collapser.sv
tb/sv/html_text_collapser_tb.sv
